// File: rtl/ctfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_pkg
// Shared types, codes and constants of the flat/dark log correction pipeline.
// ----------------------------------------------------------------------------
package ctfd_pkg;

  typedef enum logic [1:0] {
    OP_DARK = 2'd0,
    OP_FLAT = 2'd1,
    OP_PROJ = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RAW_LOW  = 2'd1,
    ST_FLAT_LOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_FLAT_GAIN    = 3'd0,
    CFG_BHC_EXPONENT = 3'd1,
    CFG_SWAP_BYTES   = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4,
    CFG_CROP_WIDTH   = 3'd5,
    CFG_CROP_HEIGHT  = 3'd6
  } cfg_reg_e;

  // Logarithm unit: 32-bit argument, result in Q.28 with a 5-bit integer part.
  localparam int LOG_IN_W   = 32;
  localparam int LOG_E_W    = 5;
  localparam int LOG_FRAC_W = 28;
  localparam int LOG_OUT_W  = LOG_E_W + LOG_FRAC_W;
  localparam int LOG_LAT    = LOG_FRAC_W + 2;

  // Exponential unit: 28 fraction bits, one conditional multiply per bit.
  localparam int EXP_STEPS = 28;
  localparam int EXP_LAT   = EXP_STEPS;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
  localparam logic [63:0] HALF_Q30  = 64'd536870912;
  localparam logic signed [33:0] LOG_BIAS = 34'sd7516192768;

  // Sideband that travels beside the arithmetic.
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic        neg;
    logic        vq_zero;
    logic [20:0] v16;
    logic [9:0]  expn;
  } meta_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    bit_v = 64'd1 << 62;
    rem   = x;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Root of two raised to 2^-i, in Q1.30, as a chain of floor square roots.
  function automatic logic [31:0] exp_root(input int i);
    logic [63:0] t;
    t = 64'(ONE_Q30);
    for (int k = 1; k <= i; k++) begin
      t = isqrt64((k == 1) ? (64'd1 << 61) : (t << 30));
    end
    return t[31:0];
  endfunction

endpackage

// File: rtl/ctfd_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_log2
// Pipelined base-2 logarithm: leading-one search, normalisation, then one
// squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module ctfd_log2
  import ctfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [LOG_IN_W-1:0]  x_i,
  output logic [LOG_OUT_W-1:0] log_o
);

  logic [LOG_E_W-1:0]    e_enc;
  logic [LOG_IN_W-1:0]   xe_q;
  logic [LOG_E_W-1:0]    ee_q;
  logic [2*LOG_IN_W-3:0] norm_wide;

  logic [30:0]           m_q    [LOG_FRAC_W];
  logic [LOG_E_W-1:0]    e_q    [LOG_FRAC_W+1];
  logic [LOG_FRAC_W-1:0] frac_q [1:LOG_FRAC_W];

  always_comb begin
    e_enc = '0;
    for (int k = 0; k < LOG_IN_W; k++) begin
      if (xe_q[k] || x_i[k]) begin
        if (x_i[k]) e_enc = LOG_E_W'(k);
      end
    end
  end

  // x * 2^30 >> e places the leading one at bit 30 for every exponent.
  assign norm_wide = ((2*LOG_IN_W-2)'(xe_q) << 30) >> ee_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xe_q   <= x_i;
      ee_q   <= e_enc;
      m_q[0] <= norm_wide[30:0];
      e_q[0] <= ee_q;
    end
  end

  for (genvar k = 1; k <= LOG_FRAC_W; k++) begin : g_sq
    logic [61:0]           sq;
    logic [31:0]           t;
    logic [LOG_FRAC_W-1:0] frac_prev;

    assign sq = m_q[k-1] * m_q[k-1];
    assign t  = sq[61:30];

    if (k == 1) begin : g_first
      assign frac_prev = '0;
    end else begin : g_rest
      assign frac_prev = frac_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        frac_q[k] <= {frac_prev[LOG_FRAC_W-2:0], t[31]};
        e_q[k]    <= e_q[k-1];
      end
    end

    if (k < LOG_FRAC_W) begin : g_m
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[k] <= t[31] ? t[31:1] : t[30:0];
        end
      end
    end
  end

  assign log_o = {e_q[LOG_FRAC_W], frac_q[LOG_FRAC_W]};

endmodule

// File: rtl/ctfd_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_exp2
// Pipelined 2^f for a 28-bit fraction f: each stage multiplies by the root
// of two that belongs to its fraction bit when that bit is set.
// ----------------------------------------------------------------------------
module ctfd_exp2
  import ctfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [EXP_STEPS-1:0] f_i,
  output logic [31:0]          r_o
);

  logic [31:0]          r_q [1:EXP_STEPS];
  logic [EXP_STEPS-1:0] f_q [1:EXP_STEPS-1];

  for (genvar i = 1; i <= EXP_STEPS; i++) begin : g_step
    localparam logic [31:0] ROOT = exp_root(i);
    logic [31:0]          r_prev;
    logic [EXP_STEPS-1:0] f_prev;
    logic [63:0]          prod;

    if (i == 1) begin : g_first
      assign r_prev = ONE_Q30;
      assign f_prev = f_i;
    end else begin : g_rest
      assign r_prev = r_q[i-1];
      assign f_prev = f_q[i-1];
    end

    assign prod = 64'(r_prev) * 64'(ROOT) + HALF_Q30;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= f_prev[EXP_STEPS-i] ? prod[61:30] : r_prev;
      end
    end

    if (i < EXP_STEPS) begin : g_f
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          f_q[i] <= f_prev;
        end
      end
    end
  end

  assign r_o = r_q[EXP_STEPS];

endmodule

// File: rtl/ct_flat_dark_log_correction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct_flat_dark_log_correction_unit
// Flat/dark field correction of detector pixels with log attenuation and a
// beam hardening power term, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle as long as the output is drained.
// The datapath holds two chains of 28 squaring stages for the logarithms of
// the flat and raw terms, a third such chain for the logarithm of the
// attenuation and a 28-stage multiply chain for the power term, each stage
// built around one multiplier. Dark and flat loads write the two frame stores,
// each a single memory of MAX_WIDTH*MAX_HEIGHT words with one write and one
// registered read per cycle; the stores are not cleared, so every entry must be
// loaded before a projection pixel reads it. A two-entry output buffer lets
// the pipeline keep running while one result waits to be taken.
// ----------------------------------------------------------------------------
module ct_flat_dark_log_correction_unit
  import ctfd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column [9:0], row [19:10], raw_pixel [35:20], zero [39:36]
  input  logic [39:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // attenuation [31:0]
  output logic [31:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [15:0] flat_gain_q;
  logic [14:0] bhc_exp_q;
  logic        swap_q;
  logic [10:0] frame_w_q, frame_h_q, crop_w_q, crop_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_gain_q <= 16'd16384;
      bhc_exp_q   <= 15'd4096;
      swap_q      <= 1'b0;
      frame_w_q   <= 11'd1024;
      frame_h_q   <= 11'd1024;
      crop_w_q    <= 11'd1024;
      crop_h_q    <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FLAT_GAIN:    flat_gain_q <= cfg_data_i;
        CFG_BHC_EXPONENT: bhc_exp_q   <= cfg_data_i[14:0];
        CFG_SWAP_BYTES:   swap_q      <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  frame_w_q   <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT: frame_h_q   <= cfg_data_i[10:0];
        CFG_CROP_WIDTH:   crop_w_q    <= cfg_data_i[10:0];
        CFG_CROP_HEIGHT:  crop_h_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame and window geometry
  // --------------------------------------------------------------------------
  logic [12:0] fw13, fh13, w13, h13, cw13, ch13;
  logic [12:0] col_lo, col_hi, row_lo, row_hi;
  logic [13:0] col_sum, row_sum;

  always_comb begin
    fw13 = 13'(frame_w_q);
    fh13 = 13'(frame_h_q);
    if (fw13 == 13'd0)                w13 = 13'd1;
    else if (fw13 > 13'(MAX_WIDTH))   w13 = 13'(MAX_WIDTH);
    else                              w13 = fw13;
    if (fh13 == 13'd0)                h13 = 13'd1;
    else if (fh13 > 13'(MAX_HEIGHT))  h13 = 13'(MAX_HEIGHT);
    else                              h13 = fh13;
    cw13    = (13'(crop_w_q) > w13) ? w13 : 13'(crop_w_q);
    ch13    = (13'(crop_h_q) > h13) ? h13 : 13'(crop_h_q);
    col_lo  = (w13 - cw13) >> 1;
    row_lo  = (h13 - ch13) >> 1;
    col_sum = 14'(w13) + 14'(cw13);
    row_sum = 14'(h13) + 14'(ch13);
    col_hi  = col_sum[13:1];
    row_hi  = row_sum[13:1];
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic        en;
  logic        accept;
  logic [9:0]  in_col, in_row;
  logic [15:0] in_raw, pix;
  logic [12:0] col13, row13;
  logic        in_frame, in_window;
  logic        wr_dark, wr_flat, is_proj;
  logic [23:0] addr_wide;
  logic [AW-1:0] addr;

  assign accept = s_axis_tvalid && en;
  assign s_axis_tready = en;

  assign in_col = s_axis_tdata[9:0];
  assign in_row = s_axis_tdata[19:10];
  assign in_raw = s_axis_tdata[35:20];
  assign pix    = swap_q ? {in_raw[7:0], in_raw[15:8]} : in_raw;
  assign col13  = 13'(in_col);
  assign row13  = 13'(in_row);

  assign in_frame  = (col13 < w13) && (row13 < h13);
  assign in_window = (col13 >= col_lo) && (col13 < col_hi) &&
                     (row13 >= row_lo) && (row13 < row_hi);

  always_comb begin
    wr_dark = 1'b0;
    wr_flat = 1'b0;
    is_proj = 1'b0;
    unique case (opcode_e'(s_axis_tuser))
      OP_DARK: wr_dark = accept && in_frame;
      OP_FLAT: wr_flat = accept && in_frame;
      OP_PROJ: is_proj = in_frame && in_window;
      default: ;
    endcase
  end

  assign addr_wide = 24'(in_row) * 24'(MAX_WIDTH) + 24'(in_col);
  assign addr      = addr_wide[AW-1:0];

  // --------------------------------------------------------------------------
  // Frame stores
  // --------------------------------------------------------------------------
  logic [15:0] dark_mem [DEPTH];
  logic [15:0] flat_mem [DEPTH];
  logic [15:0] dark_rd_q, flat_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_dark) dark_mem[addr] <= pix;
    if (en)      dark_rd_q <= dark_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_flat) flat_mem[addr] <= pix;
    if (en)      flat_rd_q <= flat_mem[addr];
  end

  // --------------------------------------------------------------------------
  // Front stages: gain product, dark subtraction, special cases
  // --------------------------------------------------------------------------
  logic        v1_q, v2_q;
  logic [15:0] raw1_q;
  logic [31:0] g2_q;
  logic [29:0] d2_q;
  logic        rle2_q;
  logic [15:0] rdiff2_q;
  meta_t       m3_d, m3_q;
  logic [31:0] a3_q;
  logic [29:0] b3_q;
  logic [31:0] b3_ext;

  always_comb begin
    m3_d       = '0;
    m3_d.valid = v2_q;
    if (rle2_q)                  m3_d.status = ST_RAW_LOW;
    else if (g2_q <= 32'(d2_q))  m3_d.status = ST_FLAT_LOW;
    else                         m3_d.status = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw1_q   <= pix;
      g2_q     <= flat_gain_q * flat_rd_q;
      d2_q     <= {dark_rd_q, 14'd0};
      rle2_q   <= raw1_q <= dark_rd_q;
      rdiff2_q <= raw1_q - dark_rd_q;
      a3_q     <= g2_q - 32'(d2_q);
      b3_q     <= {rdiff2_q, 14'd0};
    end
  end

  assign b3_ext = 32'(b3_q);

  // --------------------------------------------------------------------------
  // Logarithms of the flat and raw terms
  // --------------------------------------------------------------------------
  logic [LOG_OUT_W-1:0] log_a, log_b, log_c;

  ctfd_log2 u_log_a (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (a3_q),
    .log_o (log_a)
  );

  ctfd_log2 u_log_b (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (b3_ext),
    .log_o (log_b)
  );

  // --------------------------------------------------------------------------
  // Attenuation v in Q.28 and Q16.16
  // --------------------------------------------------------------------------
  meta_t               meta_a_q [LOG_LAT];
  meta_t               m4_d, m4_q, m5_q, m6_q, mc_in;
  logic signed [33:0]  w_full;
  logic [32:0]         w4_q;
  logic [62:0]         prod5_q;
  logic [63:0]         vq_sum;
  logic [31:0]         vq6_q;
  logic [32:0]         v16_sum;

  assign w_full = $signed({1'b0, log_a}) - $signed({1'b0, log_b});

  always_comb begin
    m4_d     = meta_a_q[LOG_LAT-1];
    m4_d.neg = w_full[33];
  end

  assign vq_sum  = 64'(prod5_q) + HALF_Q30;
  assign v16_sum = 33'(vq6_q) + 33'd2048;

  always_comb begin
    mc_in         = m6_q;
    mc_in.v16     = v16_sum[32:12];
    mc_in.vq_zero = (vq6_q == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w4_q    <= w_full[32:0];
      prod5_q <= 63'(w4_q) * 63'(LN2_Q30);
      vq6_q   <= vq_sum[61:30];
    end
  end

  ctfd_log2 u_log_c (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (vq6_q),
    .log_o (log_c)
  );

  // --------------------------------------------------------------------------
  // Power term v^c through 2^(c*log2 v)
  // --------------------------------------------------------------------------
  meta_t               meta_c_q [LOG_LAT];
  meta_t               meta_e_q [EXP_LAT];
  meta_t               m7_q, m8_d, m8_q, m9_q;
  logic signed [33:0]  lg;
  logic signed [15:0]  c16;
  logic signed [49:0]  p7_q;
  logic [EXP_STEPS-1:0] f8_q;
  logic [31:0]         exp_r;
  logic [31:0]         pw9_q;

  assign lg  = $signed({1'b0, log_c}) - LOG_BIAS;
  assign c16 = $signed({1'b0, bhc_exp_q});

  always_comb begin
    m8_d      = m7_q;
    m8_d.expn = p7_q[49:40];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p7_q <= lg * c16;
      f8_q <= p7_q[39:12];
    end
  end

  ctfd_exp2 u_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (f8_q),
    .r_o   (exp_r)
  );

  // Scale the Q1.30 mantissa by 2^(n-14) into Q16.16.
  logic signed [10:0] sh_k;
  logic [10:0]        sh_neg;
  logic [5:0]         sh_r;
  logic [63:0]        sh_left, sh_right;
  logic [31:0]        pw9_d;

  always_comb begin
    sh_k     = $signed({meta_e_q[EXP_LAT-1].expn[9], meta_e_q[EXP_LAT-1].expn}) - 11'sd14;
    sh_neg   = 11'(-sh_k);
    sh_r     = sh_neg[5:0];
    sh_left  = 64'(exp_r) << sh_k[4:0];
    sh_right = (64'(exp_r) + (64'd1 << (sh_r - 6'd1))) >> sh_r;
    if (!sh_k[10]) begin
      if (sh_k > 11'sd31)               pw9_d = SAT32;
      else if (sh_left > 64'(SAT32))    pw9_d = SAT32;
      else                              pw9_d = sh_left[31:0];
    end else if (sh_neg >= 11'd63) begin
      pw9_d = 32'd0;
    end else begin
      pw9_d = sh_right[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw9_q <= pw9_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sideband pipeline
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      m3_q <= '0;
      m4_q <= '0;
      m5_q <= '0;
      m6_q <= '0;
      m7_q <= '0;
      m8_q <= '0;
      m9_q <= '0;
      for (int k = 0; k < LOG_LAT; k++) begin
        meta_a_q[k] <= '0;
        meta_c_q[k] <= '0;
      end
      for (int k = 0; k < EXP_LAT; k++) begin
        meta_e_q[k] <= '0;
      end
    end else if (en) begin
      v1_q        <= accept && is_proj;
      v2_q        <= v1_q;
      m3_q        <= m3_d;
      meta_a_q[0] <= m3_q;
      for (int k = 1; k < LOG_LAT; k++) begin
        meta_a_q[k] <= meta_a_q[k-1];
      end
      m4_q        <= m4_d;
      m5_q        <= m4_q;
      m6_q        <= m5_q;
      meta_c_q[0] <= mc_in;
      for (int k = 1; k < LOG_LAT; k++) begin
        meta_c_q[k] <= meta_c_q[k-1];
      end
      m7_q        <= meta_c_q[LOG_LAT-1];
      m8_q        <= m8_d;
      meta_e_q[0] <= m8_q;
      for (int k = 1; k < EXP_LAT; k++) begin
        meta_e_q[k] <= meta_e_q[k-1];
      end
      m9_q        <= meta_e_q[EXP_LAT-1];
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly and output buffer
  // --------------------------------------------------------------------------
  logic [31:0] pw_sel, att;
  logic [32:0] att_sum;

  always_comb begin
    if (bhc_exp_q == 15'd0)  pw_sel = 32'd65536;
    else if (m9_q.vq_zero)   pw_sel = 32'd0;
    else                     pw_sel = pw9_q;
    att_sum = 33'(pw_sel) + 33'(m9_q.v16);
    case (m9_q.status)
      ST_RAW_LOW:  att = SAT32;
      ST_FLAT_LOW: att = 32'd0;
      default: begin
        if (m9_q.neg)        att = 32'd0;
        else if (att_sum[32]) att = SAT32;
        else                 att = att_sum[31:0];
      end
    endcase
  end

  logic [31:0] buf_att_q [2];
  logic [1:0]  buf_st_q  [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  // The pipeline moves whenever the buffer has room for one more result.
  assign en   = (count_q != 2'd2);
  assign push = en && m9_q.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_att_q[wr_ptr_q] <= att;
      buf_st_q[wr_ptr_q]  <= m9_q.status;
    end
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = buf_att_q[rd_ptr_q];
  assign m_axis_tuser  = buf_st_q[rd_ptr_q];

endmodule

// File: test/ct_flat_dark_log_correction_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ct_flat_dark_log_correction_unit_test
// Self-checking bench for the flat/dark log correction unit. Dark and flat
// frames are loaded, then projection pixels are streamed under several
// register settings. A bit-exact fixed-point model of the correction predicts
// each attenuation and status, and every result is compared in order.
// ----------------------------------------------------------------------------
module ct_flat_dark_log_correction_unit_test
  import ctfd_pkg::*;
();

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int         FRAME_MAX = 1024;
  localparam int         DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [31:0] att;
    status_e     st;
  } atten_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  ct_flat_dark_log_correction_unit u_top (.*);

  // Model copy of the registers and the two frame stores.
  logic [15:0] gain_q;
  logic [14:0] bhc_q;
  logic        swap_q;
  logic [10:0] fw_q, fh_q, cw_q, ch_q;
  logic [15:0] dark_mem [int];
  logic [15:0] flat_mem [int];
  int          loaded_addrs [$];
  bit          loaded_flag [int];
  logic [63:0] root_tab [1:28];

  atten_t      atten_q [$];
  int          errors;
  int          stall_req;
  bit          tx_idle_en;
  bit          rx_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res, b, rem;
    res = '0;
    rem = x;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_q28(input logic [63:0] x);
    int          e;
    logic [63:0] m, frac;
    e = 0;
    frac = '0;
    if (x == 0) return '0;
    for (int k = 0; k < 64; k++) if (x[k]) e = k;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 28) | frac;
  endfunction

  function automatic logic [63:0] pow2_q16(input longint p);
    longint      n, fr;
    logic [63:0] f28, r, mag;
    if (p >= 0) begin
      n = p >>> 40;
    end else begin
      mag = 64'(-p);
      n = -longint'((mag + ((64'd1 << 40) - 1)) >> 40);
    end
    fr = p - n * (64'sd1 <<< 40);
    f28 = 64'(fr) >> 12;
    r = 64'd1 << 30;
    for (int i = 1; i <= 28; i++)
      if (f28[28-i]) r = (r * root_tab[i] + (64'd1 << 29)) >> 30;
    n = n - 14;
    if (n >= 0) begin
      if (n > 31) return 64'(SAT32);
      r = r << n;
      return (r > 64'(SAT32)) ? 64'(SAT32) : r;
    end
    if (-n >= 63) return '0;
    return (r + (64'd1 << (-n - 1))) >> (-n);
  endfunction

  function automatic atten_t correct_pixel(input logic [15:0] raw, input logic [15:0] dk,
                                           input logic [15:0] fl);
    atten_t      res;
    logic [63:0] g, d, a, b, vq, v16, pw, sum;
    longint      w, lgv;
    res.att = '0;
    res.st = ST_OK;
    g = 64'(gain_q) * 64'(fl);
    d = 64'(dk) << 14;
    if (raw <= dk) begin
      res.att = SAT32;
      res.st = ST_RAW_LOW;
      return res;
    end
    if (g <= d) begin
      res.st = ST_FLAT_LOW;
      return res;
    end
    a = g - d;
    b = 64'(raw - dk) << 14;
    w = longint'(log2_q28(a)) - longint'(log2_q28(b));
    if (w < 0) return res;
    vq = (64'(w) * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
    v16 = (vq + (64'd1 << 11)) >> 12;
    if (bhc_q == 0) pw = 64'd65536;
    else if (vq == 0) pw = '0;
    else begin
      lgv = longint'(log2_q28(vq)) - (longint'(28) <<< 28);
      pw = pow2_q16(lgv * longint'(bhc_q));
    end
    sum = pw + v16;
    res.att = (sum > 64'(SAT32)) ? SAT32 : sum[31:0];
    return res;
  endfunction

  function automatic int eff_w();
    return (fw_q < 1) ? 1 : (fw_q > FRAME_MAX) ? FRAME_MAX : int'(fw_q);
  endfunction

  function automatic int eff_h();
    return (fh_q < 1) ? 1 : (fh_q > FRAME_MAX) ? FRAME_MAX : int'(fh_q);
  endfunction

  // True when a projection at this place yields a result.
  function automatic bit in_window(input int col, input int row);
    int w, h, cw, ch;
    w = eff_w();
    h = eff_h();
    cw = (cw_q > w) ? w : int'(cw_q);
    ch = (ch_q > h) ? h : int'(ch_q);
    if (col >= w || row >= h) return 1'b0;
    if (col < (w - cw) / 2 || col >= (w + cw) / 2) return 1'b0;
    if (row < (h - ch) / 2 || row >= (h + ch) / 2) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one accepted request to the model and queues any result.
  function automatic void apply_pixel(input logic [1:0] op, input int col, input int row,
                                      input logic [15:0] raw);
    logic [15:0] pix;
    int          addr;
    pix = swap_q ? {raw[7:0], raw[15:8]} : raw;
    addr = row * FRAME_MAX + col;
    if (col >= eff_w() || row >= eff_h() || op == OP_NONE) return;
    if (op == OP_DARK) dark_mem[addr] = pix;
    else if (op == OP_FLAT) flat_mem[addr] = pix;
    else if (in_window(col, row)) atten_q = {atten_q, correct_pixel(pix, dark_mem[addr],
                                                                    flat_mem[addr])};
    if (op != OP_PROJ && dark_mem.exists(addr) && flat_mem.exists(addr)
        && !loaded_flag.exists(addr)) begin
      loaded_flag[addr] = 1'b1;
      loaded_addrs = {loaded_addrs, addr};
    end
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // Receiver side: random holds, plus long holds requested by a test.
  initial begin
    int rx_hold;
    rx_hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req > 0) begin
        rx_hold = stall_req;
        stall_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
        rx_hold = gap_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    atten_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (atten_q.size() == 0) begin
        $display("%0t: unexpected result att=%h status=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_r = atten_q.pop_front();
        if (m_axis_tdata !== exp_r.att) begin
          $display("%0t: attenuation expected %h actual %h", $time, exp_r.att,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Sends one request; the valid stays high afterwards until the next call
  // or end_burst, so the caller must not let time pass in between.
  task automatic send_pixel(input logic [1:0] op, input int col, input int row,
                            input logic [15:0] raw);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 99) >= 70) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, raw, row[9:0], col[9:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_pixel(op, col, row, raw);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (atten_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] gain, input logic [14:0] bhc, input logic swp,
                            input logic [10:0] fw, input logic [10:0] fh,
                            input logic [10:0] cw, input logic [10:0] ch);
    logic [15:0] vals [7];
    vals = '{gain, 16'(bhc), 16'(swp), 16'(fw), 16'(fh), 16'(cw), 16'(ch)};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_q = gain; bhc_q = bhc; swap_q = swp;
    fw_q = fw; fh_q = fh; cw_q = cw; ch_q = ch;
  endtask

  // Loads a matching dark and flat pixel.
  task automatic load_pair(input int col, input int row, input logic [15:0] dk,
                           input logic [15:0] fl);
    send_pixel(OP_DARK, col, row, dk);
    send_pixel(OP_FLAT, col, row, fl);
  endtask

  task automatic test_directed();
    load_pair(0, 0, 16'd0, 16'hFFFF);
    send_pixel(OP_PROJ, 0, 0, 16'd1);          // largest attenuation
    send_pixel(OP_PROJ, 0, 0, 16'hFFFF);
    send_pixel(OP_PROJ, 0, 0, 16'd0);          // raw not above dark
    load_pair(1023, 1023, 16'd1000, 16'd500);
    send_pixel(OP_PROJ, 1023, 1023, 16'd2000); // flat not above dark
    send_pixel(OP_PROJ, 1023, 1023, 16'd1000);
    load_pair(512, 300, 16'd100, 16'd4000);
    send_pixel(OP_PROJ, 512, 300, 16'd8000);   // raw above flat, clamps to zero
    send_pixel(OP_PROJ, 512, 300, 16'd4000);
    send_pixel(OP_PROJ, 512, 300, 16'd101);
    send_pixel(OP_NONE, 5, 5, 16'h1234);       // unknown opcode
    send_pixel(OP_NONE, 1023, 1023, 16'hFFFF);
    load_pair(682, 341, 16'h5555, 16'hAAAA);
    send_pixel(OP_PROJ, 682, 341, 16'h8000);
    end_burst();
    wait_idle();
    set_config(16'hFFFF, 15'd0, 1'b1, 11'd2047, 11'd0, 11'd2047, 11'd2047);
    // Frame height clamps to one row; the row-1 load is outside the frame.
    load_pair(7, 0, 16'h0100, 16'hFF00);
    send_pixel(OP_DARK, 7, 1, 16'hFFFF);
    send_pixel(OP_PROJ, 7, 0, 16'h0002);
    send_pixel(OP_PROJ, 7, 1, 16'h0002);
    end_burst();
    wait_idle();
  endtask

  task automatic random_item();
    int          col, row, w, h, addr, pick;
    logic [1:0]  op;
    logic [15:0] raw;
    w = eff_w();
    h = eff_h();
    pick = $urandom_range(0, 99);
    raw = ($urandom_range(0, 1)) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
    if (pick < 55 && loaded_addrs.size() > 0) begin
      addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
      col = addr % FRAME_MAX;
      row = addr / FRAME_MAX;
      if (!in_window(col, row) && $urandom_range(0, 3) != 0) begin
        col = $urandom_range(0, w - 1);
        row = $urandom_range(0, h - 1);
        op = OP_DARK;
      end else begin
        op = OP_PROJ;
      end
    end else if (pick < 90) begin
      col = $urandom_range(0, w - 1);
      row = $urandom_range(0, h - 1);
      op = $urandom_range(0, 1) ? OP_FLAT : OP_DARK;
      raw = (op == OP_FLAT) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2000));
    end else begin
      col = $urandom_range(0, 1023);
      row = $urandom_range(0, 1023);
      op = $urandom_range(0, 1) ? OP_NONE : OP_DARK;
      addr = row * FRAME_MAX + col;
      if (pick >= 96 && (!in_window(col, row) || loaded_flag.exists(addr))) op = OP_PROJ;
    end
    send_pixel(op, col, row, raw);
  endtask

  task automatic test_random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      random_item();
    end
    end_burst();
    wait_idle();
  endtask

  // Long receiver hold while requests keep coming, so the input stalls;
  // then the sender pauses until every result is in.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    stall_req = 400;
    for (int i = 0; i < 200; i++) random_item();
    end_burst();
    do @(posedge clk_i); while (atten_q.size() != 0);
    tx_idle_en = 1'b1;
    for (int i = 0; i < 40; i++) random_item();
    end_burst();
    wait_idle();
  endtask

  initial begin
    errors = 0;
    stall_req = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FLAT_GAIN;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_DARK;
    gain_q = 16'd16384; bhc_q = 15'd4096; swap_q = 1'b0;
    fw_q = 11'd1024; fh_q = 11'd1024; cw_q = 11'd1024; ch_q = 11'd1024;
    root_tab[1] = floor_sqrt(64'd1 << 61);
    for (int i = 2; i <= 28; i++) root_tab[i] = floor_sqrt(root_tab[i-1] << 30);
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_config(16'd16384, 15'd4096, 1'b0, 11'd1024, 11'd1024, 11'd1024, 11'd1024);
    test_random_phase(150);
    set_config(16'd0, 15'd16384, 1'b0, 11'd16, 11'd12, 11'd10, 11'd7);
    test_random_phase(130);
    set_config(16'hFFFF, 15'd16384, 1'b1, 11'd16, 11'd12, 11'd20, 11'd20);
    test_random_phase(130);
    set_config(16'd20000, 15'd0, 1'b0, 11'd8, 11'd8, 11'd0, 11'd8);
    test_random_phase(60);
    set_config(16'($urandom()), 15'($urandom_range(0, 16384)), 1'b0, 11'd1024, 11'd1024,
               11'd900, 11'd1023);
    test_random_phase(150);
    set_config(16'd16384, 15'd6000, 1'b0, 11'd10, 11'd10, 11'd9, 11'd10);
    test_backpressure();
    set_config(16'($urandom()), 15'($urandom_range(1, 16384)), 1'b1, 11'd2047, 11'd2047,
               11'd1024, 11'd1024);
    test_random_phase(150);
    set_config(16'd32768, 15'd2048, 1'b0, 11'd1, 11'd1, 11'd1, 11'd1);
    test_random_phase(40);

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
